/* src/bcd_acc_pkg.sv */
// Shared types and constants for the packed BCD accumulator.
`timescale 1ns / 1ps

package bcd_acc_pkg;

    // Fixed field widths of the word interface
    localparam int VALUE_W    = 64;
    localparam int MODE_W     = 3;
    localparam int COUNT_W    = 5;
    localparam int NIB_W      = 4;

    // Default and largest number of decimal digits held
    localparam int DIGITS_DEF = 16;

    // Decimal constants
    localparam logic [NIB_W-1:0]   DEC_MAX  = 4'd9;
    localparam logic [NIB_W:0]     DEC_BASE = 5'd10;

    // Operation codes; codes six and seven behave as compare
    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD      = 3'd0,
        MODE_ADD       = 3'd1,
        MODE_INC       = 3'd2,
        MODE_SHL       = 3'd3,
        MODE_SHR       = 3'd4,
        MODE_COMPARE   = 3'd5
    } mode_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PASS,
        ST_DONE
    } state_t;

endpackage

/* src/bcd_accumulator_unit.sv */
// Packed BCD accumulator with digit-serial load, add, increment, shift, compare and digit count.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_ready) carries one word: mode, operand and
//   shift_amount. Output channel (out_valid / out_ready) returns one word per
//   input word: value, digit_count, less_than, equal_to, overflow, bad_digit.
//   The block works on one word at a time. A shift mode first moves the
//   accumulator one digit per cycle, min(shift_amount, DIGITS) digits in all;
//   then a single pass walks all DIGITS digits, least significant first, one
//   digit per cycle through the accumulator and operand shift registers,
//   forming the new digit, the carry, the comparison and the digit count.
//   The result sits in an output register, so the next word is accepted while
//   the previous result still waits; a stalled receiver holds the block in its
//   final state only when a second result is ready to go.
//   Reset clears the accumulator to zero and drops any pending result.
module bcd_accumulator_unit #(
    parameter int DIGITS = bcd_acc_pkg::DIGITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [bcd_acc_pkg::MODE_W-1:0]     mode,
    input  logic [bcd_acc_pkg::VALUE_W-1:0]    operand,
    input  logic [bcd_acc_pkg::COUNT_W-1:0]    shift_amount,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [bcd_acc_pkg::VALUE_W-1:0]    value,
    output logic [bcd_acc_pkg::COUNT_W-1:0]    digit_count,
    output logic                               less_than,
    output logic                               equal_to,
    output logic                               overflow,
    output logic                               bad_digit
);

    localparam int ACC_W = DIGITS * bcd_acc_pkg::NIB_W;
    localparam int NW    = bcd_acc_pkg::NIB_W;
    localparam int CW    = bcd_acc_pkg::COUNT_W;
    localparam logic [CW-1:0] DIG_LAST = CW'(DIGITS - 1);
    localparam logic [CW-1:0] DIG_NUM  = CW'(DIGITS);

    // Sequencer and datapath registers
    bcd_acc_pkg::state_t state_reg, state_next;
    bcd_acc_pkg::mode_t  mode_reg, mode_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [ACC_W-1:0]    op_reg, op_next;
    logic [CW-1:0]       shl_cnt_reg, shl_cnt_next;
    logic [CW-1:0]       dig_reg, dig_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                carry_reg, carry_next;
    logic                lt_reg, lt_next;
    logic                eq_reg, eq_next;
    logic                bad_reg, bad_next;

    // Output word registers
    logic                                   out_valid_reg, out_valid_next;
    logic [bcd_acc_pkg::VALUE_W-1:0]        value_reg, value_next;
    logic [CW-1:0]                          digit_count_reg, digit_count_next;
    logic                                   less_reg, less_next;
    logic                                   equal_reg, equal_next;
    logic                                   overflow_reg, overflow_next;
    logic                                   bad_out_reg, bad_out_next;

    // Per-digit datapath signals
    logic [NW-1:0] op_raw;
    logic [NW-1:0] op_dig;
    logic          op_bad;
    logic [NW-1:0] acc_dig;
    logic [NW:0]   sum;
    logic [NW-1:0] new_dig;
    logic          new_carry;
    logic [CW-1:0] shift_len;
    bcd_acc_pkg::mode_t in_mode;

    assign in_mode   = bcd_acc_pkg::mode_t'(mode);
    assign shift_len = (shift_amount >= DIG_NUM) ? DIG_NUM : shift_amount;

    // Form one result digit from the low digits of accumulator and operand
    always_comb
    begin
        op_raw    = op_reg[NW-1:0];
        op_bad    = (op_raw > bcd_acc_pkg::DEC_MAX);
        op_dig    = op_bad ? bcd_acc_pkg::DEC_MAX : op_raw;
        acc_dig   = acc_reg[NW-1:0];
        sum       = {1'b0, acc_dig} + {4'b0, carry_reg};
        new_dig   = acc_dig;
        new_carry = 1'b0;
        case (mode_reg)
            bcd_acc_pkg::MODE_LOAD:
            begin
                new_dig = op_dig;
            end
            bcd_acc_pkg::MODE_ADD,
            bcd_acc_pkg::MODE_INC:
            begin
                if (mode_reg == bcd_acc_pkg::MODE_ADD)
                begin
                    sum = {1'b0, acc_dig} + {1'b0, op_dig} + {4'b0, carry_reg};
                end
                if (sum > {1'b0, bcd_acc_pkg::DEC_MAX})
                begin
                    new_dig   = NW'(sum - bcd_acc_pkg::DEC_BASE);
                    new_carry = 1'b1;
                end
                else
                begin
                    new_dig = sum[NW-1:0];
                end
            end
            default:
            begin
                new_dig = acc_dig;
            end
        endcase
    end

    // Next state and register updates
    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        acc_next         = acc_reg;
        op_next          = op_reg;
        shl_cnt_next     = shl_cnt_reg;
        dig_next         = dig_reg;
        cnt_next         = cnt_reg;
        carry_next       = carry_reg;
        lt_next          = lt_reg;
        eq_next          = eq_reg;
        bad_next         = bad_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        value_next       = value_reg;
        digit_count_next = digit_count_reg;
        less_next        = less_reg;
        equal_next       = equal_reg;
        overflow_next    = overflow_reg;
        bad_out_next     = bad_out_reg;
        in_ready         = 1'b0;

        case (state_reg)
            bcd_acc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mode_next  = in_mode;
                    op_next    = operand[ACC_W-1:0];
                    dig_next   = '0;
                    cnt_next   = '0;
                    carry_next = (in_mode == bcd_acc_pkg::MODE_INC);
                    lt_next    = 1'b0;
                    eq_next    = 1'b1;
                    bad_next   = 1'b0;
                    if ((in_mode == bcd_acc_pkg::MODE_SHL ||
                         in_mode == bcd_acc_pkg::MODE_SHR) && shift_len != '0)
                    begin
                        shl_cnt_next = shift_len;
                        state_next   = bcd_acc_pkg::ST_SHIFT;
                    end
                    else
                    begin
                        state_next = bcd_acc_pkg::ST_PASS;
                    end
                end
            end
            bcd_acc_pkg::ST_SHIFT:
            begin
                // Move the accumulator one digit, zero fill
                if (mode_reg == bcd_acc_pkg::MODE_SHL)
                begin
                    acc_next = {acc_reg[ACC_W-NW-1:0], {NW{1'b0}}};
                end
                else
                begin
                    acc_next = {{NW{1'b0}}, acc_reg[ACC_W-1:NW]};
                end
                shl_cnt_next = shl_cnt_reg - 1'b1;
                if (shl_cnt_reg == CW'(1))
                begin
                    state_next = bcd_acc_pkg::ST_PASS;
                end
            end
            bcd_acc_pkg::ST_PASS:
            begin
                // Rotate the new digit in at the top, advance the operand
                acc_next   = {new_dig, acc_reg[ACC_W-1:NW]};
                op_next    = {{NW{1'b0}}, op_reg[ACC_W-1:NW]};
                carry_next = new_carry;
                bad_next   = bad_reg | op_bad;
                if (new_dig != op_dig)
                begin
                    lt_next = (new_dig < op_dig);
                    eq_next = 1'b0;
                end
                if (new_dig != '0)
                begin
                    cnt_next = dig_reg + 1'b1;
                end
                dig_next = dig_reg + 1'b1;
                if (dig_reg == DIG_LAST)
                begin
                    state_next = bcd_acc_pkg::ST_DONE;
                end
            end
            bcd_acc_pkg::ST_DONE:
            begin
                // Hand the word to the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    value_next       = bcd_acc_pkg::VALUE_W'(acc_reg);
                    digit_count_next = cnt_reg;
                    less_next        = lt_reg;
                    equal_next       = eq_reg;
                    overflow_next    = carry_reg;
                    bad_out_next     = bad_reg;
                    state_next       = bcd_acc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bcd_acc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bcd_acc_pkg::ST_IDLE;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            shl_cnt_reg   <= '0;
            dig_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            shl_cnt_reg   <= shl_cnt_next;
            dig_reg       <= dig_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        op_reg          <= op_next;
        cnt_reg         <= cnt_next;
        carry_reg       <= carry_next;
        lt_reg          <= lt_next;
        eq_reg          <= eq_next;
        bad_reg         <= bad_next;
        value_reg       <= value_next;
        digit_count_reg <= digit_count_next;
        less_reg        <= less_next;
        equal_reg       <= equal_next;
        overflow_reg    <= overflow_next;
        bad_out_reg     <= bad_out_next;
    end

    assign out_valid   = out_valid_reg;
    assign value       = value_reg;
    assign digit_count = digit_count_reg;
    assign less_than   = less_reg;
    assign equal_to    = equal_reg;
    assign overflow    = overflow_reg;
    assign bad_digit   = bad_out_reg;

    // Every digit written back during the pass is decimal
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bcd_acc_pkg::ST_PASS) |-> (new_dig <= bcd_acc_pkg::DEC_MAX))
        else $error("non-decimal digit written to accumulator");

    // Overflow can only come from add or increment
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bcd_acc_pkg::ST_DONE && carry_reg) |->
        (mode_reg == bcd_acc_pkg::MODE_ADD || mode_reg == bcd_acc_pkg::MODE_INC))
        else $error("carry left set by a mode without addition");

    // Less and equal are never both set on a finished word
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bcd_acc_pkg::ST_DONE) |-> !(lt_reg && eq_reg))
        else $error("comparison flags contradict");

    // The shift phase always has digits left to move and the pass starts at digit zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bcd_acc_pkg::ST_SHIFT) |-> (shl_cnt_reg != '0 && dig_reg == '0))
        else $error("shift phase entered with nothing to shift");

    // A reported digit count never exceeds the width
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (digit_count_reg <= DIG_NUM))
        else $error("digit count beyond accumulator width");

endmodule

/* verif/tb.sv */
// Self-checking testbench for the packed BCD accumulator: directed table, then random words.
`timescale 1ns / 1ps

module tb;

    localparam int DIGITS       = bcd_acc_pkg::DIGITS_DEF;
    localparam int VALUE_W      = bcd_acc_pkg::VALUE_W;
    localparam int MODE_W       = bcd_acc_pkg::MODE_W;
    localparam int COUNT_W      = bcd_acc_pkg::COUNT_W;
    localparam int NIB_W        = bcd_acc_pkg::NIB_W;
    localparam int RANDOM_WORDS = 600;
    localparam int PHASES       = 3;
    localparam int LONG_HOLD    = 200;
    localparam int HOLD_AFTER   = 60;
    localparam int DRAIN        = 2 * DIGITS + 8;
    localparam int CYCLE_LIMIT  = 300000;

    // Spare operation codes; the block treats them as compare
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    localparam logic [VALUE_W-1:0] ALL_NINES = 64'h9999_9999_9999_9999;
    localparam logic [VALUE_W-1:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] digits;
        logic               less;
        logic               equal;
        logic               carry_out;
        logic               bad;
    } bcd_result_t;

    typedef struct packed {
        logic [MODE_W-1:0]  op_mode;
        logic [VALUE_W-1:0] opnd;
        logic [COUNT_W-1:0] amount;
        logic               fixed;
        bcd_result_t        known;
    } stim_row_t;

    localparam int ROWS = 26;

    // Directed words; rows marked fixed carry a hand-written result
    localparam stim_row_t DIRECTED [ROWS] = '{
        '{bcd_acc_pkg::MODE_COMPARE, 64'h0, 5'd0, 1'b1, '{64'h0, 5'd0, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{bcd_acc_pkg::MODE_LOAD, ALL_NINES, 5'd0, 1'b1,
          '{ALL_NINES, 5'd16, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{bcd_acc_pkg::MODE_INC, 64'h0, 5'd0, 1'b1, '{64'h0, 5'd0, 1'b0, 1'b1, 1'b1, 1'b0}},
        '{bcd_acc_pkg::MODE_LOAD, ALL_ONES, 5'd0, 1'b1,
          '{ALL_NINES, 5'd16, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{bcd_acc_pkg::MODE_ADD, 64'h1, 5'd0, 1'b1, '{64'h0, 5'd0, 1'b1, 1'b0, 1'b1, 1'b0}},
        '{bcd_acc_pkg::MODE_LOAD, 64'h1234_5678_9012_3456, 5'd0, 1'b0, '0},
        '{bcd_acc_pkg::MODE_SHL, 64'h0, 5'd0,  1'b0, '0},
        '{bcd_acc_pkg::MODE_SHL, 64'h0, 5'd1,  1'b0, '0},
        '{bcd_acc_pkg::MODE_SHR, 64'h0, 5'd3,  1'b0, '0},
        '{bcd_acc_pkg::MODE_SHL, 64'h0, 5'd15, 1'b0, '0},
        '{bcd_acc_pkg::MODE_SHR, 64'h0, 5'd16, 1'b1, '{64'h0, 5'd0, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{bcd_acc_pkg::MODE_LOAD, 64'h5, 5'd0, 1'b0, '0},
        '{bcd_acc_pkg::MODE_SHL, 64'h0, 5'd31, 1'b1, '{64'h0, 5'd0, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{bcd_acc_pkg::MODE_LOAD, 64'h9000_0000_0000_0000, 5'd0, 1'b0, '0},
        '{bcd_acc_pkg::MODE_SHR, 64'h0, 5'd15, 1'b0, '0},
        '{bcd_acc_pkg::MODE_ADD, 64'h9, 5'd0,  1'b0, '0},
        '{bcd_acc_pkg::MODE_INC, 64'h0, 5'd0,  1'b0, '0},
        '{bcd_acc_pkg::MODE_ADD, 64'hA0B0_C0D0_E0F0_0000, 5'd0, 1'b0, '0},
        '{MODE_SPARE_LO, ALL_ONES, 5'd0, 1'b0, '0},
        '{MODE_SPARE_HI, 64'h0, 5'd9,  1'b0, '0},
        '{bcd_acc_pkg::MODE_COMPARE, 64'h0000_0000_0001_0000, 5'd0, 1'b0, '0},
        '{bcd_acc_pkg::MODE_LOAD, 64'h8765_4321_0000_0001, 5'd0, 1'b0, '0},
        '{bcd_acc_pkg::MODE_ADD, 64'h1234_5678_9999_9999, 5'd0, 1'b0, '0},
        '{bcd_acc_pkg::MODE_LOAD, 64'h0000_0000_0009_9999, 5'd0, 1'b0, '0},
        '{bcd_acc_pkg::MODE_INC, 64'h0, 5'd0,  1'b0, '0},
        '{bcd_acc_pkg::MODE_SHR, 64'h0, 5'd17, 1'b0, '0}
    };

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] operand;
    logic [COUNT_W-1:0] shift_amount;
    logic               out_valid;
    logic               out_ready;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] digit_count;
    logic               less_than;
    logic               equal_to;
    logic               overflow;
    logic               bad_digit;

    logic [VALUE_W-1:0] acc_model;
    bcd_result_t        pending_results [$];
    int                 error_count;
    int                 words_checked;
    int                 sender_idle_pct;
    int                 receiver_idle_pct;
    int                 cycle_count;

    bcd_accumulator_unit DUT (.*);

    // Free-running clock, 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Apply one word to the accumulator copy and form its result
    function automatic bcd_result_t bcd_apply(input logic [MODE_W-1:0] m,
                                              input logic [VALUE_W-1:0] raw,
                                              input logic [COUNT_W-1:0] amt);
        bcd_result_t        r;
        logic [VALUE_W-1:0] clean_op;
        logic [VALUE_W-1:0] addend;
        logic [VALUE_W-1:0] nxt;
        logic [NIB_W:0]     sum;
        logic               carry;
        logic               bad;
        int                 d;
        clean_op = '0;
        bad = 1'b0;
        // Saturate non-decimal nibbles to nine
        for (d = 0; d < DIGITS; d++)
        begin
            if (raw[NIB_W*d +: NIB_W] > bcd_acc_pkg::DEC_MAX)
            begin
                clean_op[NIB_W*d +: NIB_W] = bcd_acc_pkg::DEC_MAX;
                bad = 1'b1;
            end
            else
                clean_op[NIB_W*d +: NIB_W] = raw[NIB_W*d +: NIB_W];
        end
        nxt = acc_model;
        carry = 1'b0;
        case (m)
            bcd_acc_pkg::MODE_LOAD: nxt = clean_op;
            bcd_acc_pkg::MODE_ADD, bcd_acc_pkg::MODE_INC:
            begin
                addend = (m == bcd_acc_pkg::MODE_ADD) ? clean_op : 64'd1;
                for (d = 0; d < DIGITS; d++)
                begin
                    sum = {1'b0, acc_model[NIB_W*d +: NIB_W]}
                        + {1'b0, addend[NIB_W*d +: NIB_W]} + {{NIB_W{1'b0}}, carry};
                    carry = (sum >= bcd_acc_pkg::DEC_BASE);
                    if (carry)
                        sum = sum - bcd_acc_pkg::DEC_BASE;
                    nxt[NIB_W*d +: NIB_W] = sum[NIB_W-1:0];
                end
            end
            bcd_acc_pkg::MODE_SHL: nxt = (amt >= DIGITS) ? '0 : acc_model << (NIB_W * amt);
            bcd_acc_pkg::MODE_SHR: nxt = (amt >= DIGITS) ? '0 : acc_model >> (NIB_W * amt);
            default: ;
        endcase
        r.value = nxt;
        r.digits = '0;
        for (d = 0; d < DIGITS; d++)
            if (nxt[NIB_W*d +: NIB_W] != '0)
                r.digits = COUNT_W'(d + 1);
        r.less = (nxt < clean_op);
        r.equal = (nxt == clean_op);
        r.carry_out = carry;
        r.bad = bad;
        acc_model = nxt;
        return r;
    endfunction

    function automatic logic [MODE_W-1:0] random_mode();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)      return bcd_acc_pkg::MODE_LOAD;
        else if (pick < 40) return bcd_acc_pkg::MODE_ADD;
        else if (pick < 52) return bcd_acc_pkg::MODE_INC;
        else if (pick < 65) return bcd_acc_pkg::MODE_SHL;
        else if (pick < 78) return bcd_acc_pkg::MODE_SHR;
        else if (pick < 94) return bcd_acc_pkg::MODE_COMPARE;
        else if (pick < 97) return MODE_SPARE_LO;
        else                return MODE_SPARE_HI;
    endfunction

    // Mostly decimal numbers of varying length, some with bad nibbles or raw bits
    function automatic logic [VALUE_W-1:0] random_operand(input logic [MODE_W-1:0] m);
        logic [VALUE_W-1:0] r;
        int                 pick;
        int                 span;
        int                 d;
        pick = $urandom_range(0, 99);
        span = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : $urandom_range(1, DIGITS);
        r = '0;
        if (pick < 8)
            r = {$urandom, $urandom};
        else if (m == bcd_acc_pkg::MODE_COMPARE && pick < 40)
            r = acc_model;
        else
        begin
            for (d = 0; d < span; d++)
                r[NIB_W*d +: NIB_W] = (pick < 30) ? bcd_acc_pkg::DEC_MAX
                                                  : NIB_W'($urandom_range(0, 9));
            if (pick < 20)
                r[NIB_W*$urandom_range(0, DIGITS-1) +: NIB_W] = NIB_W'($urandom_range(10, 15));
        end
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] random_amount();
        if ($urandom_range(0, 99) < 85)
            return COUNT_W'($urandom_range(0, DIGITS));
        return COUNT_W'($urandom_range(0, 31));
    endfunction

    // Offer one word, wait for its acceptance and queue the expected result
    task automatic send_word(input logic [MODE_W-1:0] m, input logic [VALUE_W-1:0] opnd,
                             input logic [COUNT_W-1:0] amt, input logic fixed,
                             input bcd_result_t known);
        bcd_result_t predicted;
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2 * DIGITS + 2)) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        operand <= opnd;
        shift_amount <= amt;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = bcd_apply(m, opnd, amt);
        pending_results.push_back(fixed ? known : predicted);
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
        end
    endtask

    // Compare each delivered word with the oldest expectation
    always @(posedge clk)
    begin
        bcd_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            words_checked++;
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result word: expected none, got value %h",
                         $time, value);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("value", want.value, value);
                check_field("digit_count", VALUE_W'(want.digits), VALUE_W'(digit_count));
                check_field("less_than", VALUE_W'(want.less), VALUE_W'(less_than));
                check_field("equal_to", VALUE_W'(want.equal), VALUE_W'(equal_to));
                check_field("overflow", VALUE_W'(want.carry_out), VALUE_W'(overflow));
                check_field("bad_digit", VALUE_W'(want.bad), VALUE_W'(bad_digit));
            end
        end
    end

    // Drive out_ready; hold off once for a long stretch to back the block up
    initial
    begin
        bit held;
        held = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && words_checked >= HOLD_AFTER)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Stop a hung run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Reset, directed table, three random phases, then drain
    initial
    begin
        int row;
        int phase;
        int n;
        logic [MODE_W-1:0] m;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = bcd_acc_pkg::MODE_LOAD;
        operand = '0;
        shift_amount = '0;
        acc_model = '0;
        error_count = 0;
        words_checked = 0;
        sender_idle_pct = 22;
        receiver_idle_pct = 48;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (row = 0; row < ROWS; row++)
            send_word(DIRECTED[row].op_mode, DIRECTED[row].opnd, DIRECTED[row].amount,
                      DIRECTED[row].fixed, DIRECTED[row].known);

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct = 22;
                    receiver_idle_pct = 48;
                end
                1:
                begin
                    sender_idle_pct = 48;
                    receiver_idle_pct = 22;
                end
                default:
                begin
                    sender_idle_pct = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            for (n = 0; n < RANDOM_WORDS / PHASES; n++)
            begin
                m = random_mode();
                send_word(m, random_operand(m), random_amount(), 1'b0, '0);
            end
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
src/bcd_acc_pkg.sv
src/bcd_accumulator_unit.sv
verif/tb.sv
